[src/assert_macros.svh]
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define MICS_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the following cycle
`define MICS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/mics_pkg.sv]
package mics_pkg;

	localparam int unsigned DefRegisterCount = 32;
	localparam int unsigned DefWordBytes = 4;
	localparam int unsigned RegIdxW = 5;

	localparam logic [31:0] ResetAddress = 32'hbfc00000;
	localparam logic [31:0] Poison = 32'hdeadbeef;
	localparam logic [31:0] IsolateMask = 32'h00010000;
	localparam logic [31:0] JumpRegionMask = 32'hf0000000;
	localparam logic [31:0] SignBit = 32'h80000000;
	localparam logic [31:0] AllOnes = 32'hffffffff;
	localparam logic [31:0] ByteMask = 32'h000000ff;

	typedef struct packed {
		logic [31:0] fetched_word;
		logic [31:0] load_data;
	} in_item_t;

	typedef struct packed {
		logic [31:0] fetch_address;
		logic [1:0]  mem_kind;
		logic [1:0]  mem_size;
		logic [31:0] mem_address;
		logic [31:0] store_data;
		logic [2:0]  status;
	} out_item_t;

	localparam logic [1:0] KindNone = 2'd0;
	localparam logic [1:0] KindLoad = 2'd1;
	localparam logic [1:0] KindStore = 2'd2;

	localparam logic [1:0] SizeByte = 2'd0;
	localparam logic [1:0] SizeHalf = 2'd1;
	localparam logic [1:0] SizeWord = 2'd2;

	localparam logic [2:0] StOk = 3'd0;
	localparam logic [2:0] StBadOp = 3'd1;
	localparam logic [2:0] StOverflow = 3'd2;
	localparam logic [2:0] StBadCop = 3'd3;
	localparam logic [2:0] StHalted = 3'd4;

	localparam logic [1:0] PlNone = 2'd0;
	localparam logic [1:0] PlWord = 2'd1;
	localparam logic [1:0] PlSByte = 2'd2;
	localparam logic [1:0] PlUByte = 2'd3;

	localparam logic [5:0] OpSpecial = 6'h00;
	localparam logic [5:0] OpRegimm = 6'h01;
	localparam logic [5:0] OpJ = 6'h02;
	localparam logic [5:0] OpJal = 6'h03;
	localparam logic [5:0] OpBeq = 6'h04;
	localparam logic [5:0] OpBne = 6'h05;
	localparam logic [5:0] OpBlez = 6'h06;
	localparam logic [5:0] OpBgtz = 6'h07;
	localparam logic [5:0] OpAddi = 6'h08;
	localparam logic [5:0] OpAddiu = 6'h09;
	localparam logic [5:0] OpSlti = 6'h0a;
	localparam logic [5:0] OpSltiu = 6'h0b;
	localparam logic [5:0] OpAndi = 6'h0c;
	localparam logic [5:0] OpOri = 6'h0d;
	localparam logic [5:0] OpLui = 6'h0f;
	localparam logic [5:0] OpCop0 = 6'h10;
	localparam logic [5:0] OpLb = 6'h20;
	localparam logic [5:0] OpLw = 6'h23;
	localparam logic [5:0] OpLbu = 6'h24;
	localparam logic [5:0] OpSb = 6'h28;
	localparam logic [5:0] OpSh = 6'h29;
	localparam logic [5:0] OpSw = 6'h2b;

	localparam logic [5:0] FnSll = 6'h00;
	localparam logic [5:0] FnSrl = 6'h02;
	localparam logic [5:0] FnSra = 6'h03;
	localparam logic [5:0] FnJr = 6'h08;
	localparam logic [5:0] FnJalr = 6'h09;
	localparam logic [5:0] FnMfhi = 6'h10;
	localparam logic [5:0] FnMflo = 6'h12;
	localparam logic [5:0] FnDiv = 6'h1a;
	localparam logic [5:0] FnDivu = 6'h1b;
	localparam logic [5:0] FnAdd = 6'h20;
	localparam logic [5:0] FnAddu = 6'h21;
	localparam logic [5:0] FnSubu = 6'h23;
	localparam logic [5:0] FnAnd = 6'h24;
	localparam logic [5:0] FnOr = 6'h25;
	localparam logic [5:0] FnSlt = 6'h2a;
	localparam logic [5:0] FnSltu = 6'h2b;

	localparam logic [4:0] CopMt = 5'h04;
	localparam logic [4:0] CopMf = 5'h00;
	localparam logic [4:0] Cp0Sr = 5'd12;
	localparam logic [4:0] LinkReg = 5'd31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic               we;
		logic [RegIdxW-1:0] waddr;
		logic [31:0]        wdata;
		logic               re;
		logic [RegIdxW-1:0] ra;
		logic [RegIdxW-1:0] rb;
	} rf_req_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic [31:0] rem;
	} div_rsp_t;

endpackage

[src/mips_integer_core_step_top.sv]
// integer core step: one instruction executed per item
// inst channel: valid/ready, carries the fetched word and the data of the
//   previous item's load; the core executes the word it held, then holds the new one
// res channel: valid/ready, one result per item: next fetch address, data access
//   request and status
// cfg channel: always ready; the written address is not kept, so reset always
//   starts fetch at the default reset address
// an item passes through the register read state, then the execute state, into
//   the output register; div and divu with a nonzero divisor, but for the most
//   negative dividend over -1, go through the radix-2 divider and a finish state
// a new item is taken only in idle, once the last result is committed; the register
//   file read and the execute step are sequenced, the divider iterates
// the result sits in an output register; the next item is accepted while it
//   waits, and execute holds until the register is free when the receiver stalls
// reset: pc to the reset address, held word to a no-op, registers but r0 read 0xdeadbeef
// after a fault every result reports halted and nothing changes
module mips_integer_core_step_top import mics_pkg::*; #(
	parameter int unsigned REGISTER_COUNT = DefRegisterCount,
	parameter int unsigned WORD_BYTES = DefWordBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        inst_valid,
	output logic        inst_ready,
	input  in_item_t    inst_item,
	output logic        res_valid,
	input  logic        res_ready,
	output out_item_t   res_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	state_t state_q, state_d;

	logic [31:0] pc_q, held_q, ins_q, ld_q, hi_q, lo_q, sr_q;
	logic [RegIdxW-1:0] pend_t_q;
	logic [1:0]  pend_m_q;
	logic        pend_sr_q, halted_q, halt_item_q;
	logic        neg_q_q, neg_r_q;
	logic        res_valid_q;
	out_item_t   res_q;

	rf_req_t  rf_req;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic [31:0] rs, rt;

	logic accept, out_free, commit;

	mics_regfile #(.REGISTER_COUNT(REGISTER_COUNT)) u_rf (
		.clk(clk), .arst_n(arst_n), .req(rf_req), .rd_a(rs), .rd_b(rt)
	);

	mics_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// decode
	logic [5:0] op, fn;
	logic [4:0] rsi, rti, rdi, sh;
	logic [31:0] imm, simm, addr, pc_inc, br_tgt, j_tgt, sum, pld_val;
	logic isolated;

	assign op = ins_q[31:26];
	assign fn = ins_q[5:0];
	assign rsi = ins_q[25:21];
	assign rti = ins_q[20:16];
	assign rdi = ins_q[15:11];
	assign sh = ins_q[10:6];
	assign imm = {16'h0, ins_q[15:0]};
	assign simm = {{16{ins_q[15]}}, ins_q[15:0]};
	assign addr = rs + simm;
	assign sum = rs + rt;
	assign pc_inc = pc_q + 32'(WORD_BYTES);
	assign br_tgt = pc_q + {simm[29:0], 2'b00};
	assign j_tgt = (pc_q & JumpRegionMask) | {4'h0, ins_q[25:0], 2'b00};
	assign isolated = (sr_q & IsolateMask) != '0;

	logic [31:0] nx_pc, wr_val, sdata, maddr, hi_v, lo_v;
	logic [4:0]  wr_idx, new_t;
	logic [1:0]  kind, size, new_m;
	logic [2:0]  st;
	logic wr, new_sr, sr_we, hilo_we, is_div, div_signed;

	always_comb begin
		nx_pc = pc_inc;
		wr = 1'b0; wr_idx = rdi; wr_val = '0;
		st = StOk; kind = KindNone; size = SizeByte; maddr = '0; sdata = '0;
		new_t = '0; new_m = PlNone; new_sr = 1'b0; sr_we = 1'b0;
		hilo_we = 1'b0; hi_v = rs; lo_v = AllOnes; is_div = 1'b0; div_signed = 1'b0;
		case (op)
			OpSpecial: begin
				case (fn)
					FnSll: begin wr = 1'b1; wr_val = rt << sh; end
					FnSrl: begin wr = 1'b1; wr_val = rt >> sh; end
					FnSra: begin wr = 1'b1; wr_val = 32'($signed(rt) >>> sh); end
					FnJr: nx_pc = rs;
					FnJalr: begin wr = 1'b1; wr_val = pc_inc; nx_pc = rs; end
					FnMfhi: begin wr = 1'b1; wr_val = hi_q; end
					FnMflo: begin wr = 1'b1; wr_val = lo_q; end
					FnDiv: begin
						div_signed = 1'b1;
						if (rt == '0) begin
							hilo_we = 1'b1;
							lo_v = rs[31] ? 32'd1 : AllOnes;
						end else if (rs == SignBit && rt == AllOnes) begin
							hilo_we = 1'b1; hi_v = '0; lo_v = SignBit;
						end else begin
							is_div = 1'b1;
						end
					end
					FnDivu: begin
						if (rt == '0) hilo_we = 1'b1;
						else is_div = 1'b1;
					end
					FnAdd: begin
						if ((~(rs ^ rt) & (rs ^ sum) & SignBit) != '0) st = StOverflow;
						else begin wr = 1'b1; wr_val = sum; end
					end
					FnAddu: begin wr = 1'b1; wr_val = sum; end
					FnSubu: begin wr = 1'b1; wr_val = rs - rt; end
					FnAnd: begin wr = 1'b1; wr_val = rs & rt; end
					FnOr: begin wr = 1'b1; wr_val = rs | rt; end
					FnSlt: begin wr = 1'b1; wr_val = {31'h0, $signed(rs) < $signed(rt)}; end
					FnSltu: begin wr = 1'b1; wr_val = {31'h0, rs < rt}; end
					default: st = StBadOp;
				endcase
			end
			OpRegimm: begin
				if (ins_q[20]) begin wr = 1'b1; wr_idx = LinkReg; wr_val = pc_inc; end
				if (rs[31] ^ ins_q[16]) nx_pc = br_tgt;
			end
			OpJal: begin
				wr = 1'b1; wr_idx = LinkReg; wr_val = pc_inc; nx_pc = j_tgt;
			end
			OpJ: nx_pc = j_tgt;
			OpBeq: if (rs == rt) nx_pc = br_tgt;
			OpBne: if (rs != rt) nx_pc = br_tgt;
			OpBlez: if (rs == '0 || rs[31]) nx_pc = br_tgt;
			OpBgtz: if (rs != '0 && !rs[31]) nx_pc = br_tgt;
			OpAddi: begin
				wr_idx = rti;
				if ((~(rs ^ simm) & (rs ^ addr) & SignBit) != '0) st = StOverflow;
				else begin wr = 1'b1; wr_val = addr; end
			end
			OpAddiu: begin wr = 1'b1; wr_idx = rti; wr_val = addr; end
			OpSlti: begin
				wr = 1'b1; wr_idx = rti; wr_val = {31'h0, $signed(rs) < $signed(simm)};
			end
			OpSltiu: begin wr = 1'b1; wr_idx = rti; wr_val = {31'h0, rs < simm}; end
			OpAndi: begin wr = 1'b1; wr_idx = rti; wr_val = rs & imm; end
			OpOri: begin wr = 1'b1; wr_idx = rti; wr_val = rs | imm; end
			OpLui: begin wr = 1'b1; wr_idx = rti; wr_val = {ins_q[15:0], 16'h0}; end
			OpCop0: begin
				if (rsi == CopMt) begin
					if (rdi == Cp0Sr) sr_we = 1'b1;
					else if (rdi == 5'd3 || rdi == 5'd5 || rdi == 5'd6 || rdi == 5'd7 ||
						rdi == 5'd9 || rdi == 5'd11 || rdi == 5'd13) begin
						if (rt != '0) st = StBadCop;
					end else st = StBadCop;
				end else if (rsi == CopMf) begin
					if (rdi == Cp0Sr) begin new_sr = 1'b1; new_t = rti; end
					else st = StBadCop;
				end else st = StBadCop;
			end
			OpLb: begin kind = KindLoad; maddr = addr; new_t = rti; new_m = PlSByte; end
			OpLbu: begin kind = KindLoad; maddr = addr; new_t = rti; new_m = PlUByte; end
			OpLw: if (!isolated) begin
				kind = KindLoad; size = SizeWord; maddr = addr; new_t = rti; new_m = PlWord;
			end
			OpSb: if (!isolated) begin
				kind = KindStore; maddr = addr; sdata = rt & ByteMask;
			end
			OpSh: if (!isolated) begin
				kind = KindStore; size = SizeHalf; maddr = addr; sdata = {16'h0, rt[15:0]};
			end
			OpSw: if (!isolated) begin
				kind = KindStore; size = SizeWord; maddr = addr; sdata = rt;
			end
			default: st = StBadOp;
		endcase
		if (st != StOk) begin
			kind = KindNone; size = SizeByte; maddr = '0; sdata = '0;
		end
	end

	always_comb begin
		case (pend_m_q)
			PlWord: pld_val = ld_q;
			PlSByte: pld_val = {{24{ld_q[7]}}, ld_q[7:0]};
			PlUByte: pld_val = ld_q & ByteMask;
			default: pld_val = ld_q;
		endcase
		if (pend_sr_q) pld_val = sr_q;
	end

	assign out_free = !res_valid_q || res_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = halted_q ? ST_EXEC : ST_READ;
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: begin
				if (!halt_item_q && is_div) state_d = ST_DIV;
				else if (out_free) state_d = ST_IDLE;
			end
			ST_DIV: if (div_rsp.done) state_d = ST_FIN;
			ST_FIN: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		inst_ready = (state_q == ST_IDLE);
		accept = inst_valid && inst_ready;
		commit = out_free && ((state_q == ST_EXEC && (halt_item_q || !is_div)) ||
			state_q == ST_FIN);
		rf_req.re = (state_q == ST_READ);
		rf_req.ra = ins_q[25:21];
		rf_req.rb = ins_q[20:16];
		if (state_q == ST_READ) begin
			rf_req.we = pend_sr_q || pend_m_q != PlNone;
			rf_req.waddr = pend_t_q;
			rf_req.wdata = pld_val;
		end else begin
			rf_req.we = commit && state_q == ST_EXEC && !halt_item_q && st == StOk && wr;
			rf_req.waddr = wr_idx;
			rf_req.wdata = wr_val;
		end
		div_req.start = (state_q == ST_EXEC) && !halt_item_q && is_div;
		div_req.dividend = (div_signed && rs[31]) ? (32'h0 - rs) : rs;
		div_req.divisor = (div_signed && rt[31]) ? (32'h0 - rt) : rt;
	end

	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_item = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= ResetAddress;
			held_q <= '0;
			hi_q <= Poison;
			lo_q <= Poison;
			sr_q <= '0;
			pend_t_q <= '0;
			pend_m_q <= PlNone;
			pend_sr_q <= 1'b0;
			halted_q <= 1'b0;
			halt_item_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_ready) res_valid_q <= 1'b0;
			if (accept) begin
				halt_item_q <= halted_q;
				if (!halted_q) held_q <= inst_item.fetched_word;
			end
			if (state_q == ST_READ) begin
				pend_m_q <= PlNone;
				pend_sr_q <= 1'b0;
				pend_t_q <= '0;
			end
			if (state_q == ST_DIV && div_rsp.done) begin
				hi_q <= neg_r_q ? (32'h0 - div_rsp.rem) : div_rsp.rem;
				lo_q <= neg_q_q ? (32'h0 - div_rsp.quot) : div_rsp.quot;
			end
			if (commit) begin
				res_valid_q <= 1'b1;
				if (!halt_item_q) begin
					pc_q <= (state_q == ST_FIN) ? pc_inc : nx_pc;
					if (state_q == ST_EXEC) begin
						if (st != StOk) begin
							halted_q <= 1'b1;
						end else begin
							pend_t_q <= new_t;
							pend_m_q <= new_m;
							pend_sr_q <= new_sr;
							if (sr_we) sr_q <= rt;
							if (hilo_we) begin
								hi_q <= hi_v;
								lo_q <= lo_v;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !halted_q) begin
			ins_q <= held_q;
			ld_q <= inst_item.load_data;
		end
		if (div_req.start) begin
			neg_q_q <= div_signed && (rs[31] ^ rt[31]);
			neg_r_q <= div_signed && rs[31];
		end
		if (commit) begin
			if (halt_item_q) begin
				res_q <= '{fetch_address: pc_q, mem_kind: KindNone, mem_size: SizeByte,
					mem_address: '0, store_data: '0, status: StHalted};
			end else if (state_q == ST_FIN) begin
				res_q <= '{fetch_address: pc_inc, mem_kind: KindNone, mem_size: SizeByte,
					mem_address: '0, store_data: '0, status: StOk};
			end else begin
				res_q <= '{fetch_address: nx_pc, mem_kind: kind, mem_size: size,
					mem_address: maddr, store_data: sdata, status: st};
			end
		end
	end

endmodule

[src/mics_regfile.sv]
module mics_regfile import mics_pkg::*; #(
	parameter int unsigned REGISTER_COUNT = DefRegisterCount
) (
	input  logic        clk,
	input  logic        arst_n,
	input  rf_req_t     req,
	output logic [31:0] rd_a,
	output logic [31:0] rd_b
);

	logic [31:0] mem [REGISTER_COUNT];
	logic [REGISTER_COUNT-1:0] vld_q;
	logic [31:0] da_q, db_q;
	logic va_q, vb_q, za_q, zb_q;

	always_ff @(posedge clk) begin
		if (req.we && req.waddr != '0) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			da_q <= mem[req.ra];
			db_q <= mem[req.rb];
		end
	end

	// entries other than r0 never written since reset read as the poison value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q <= 1'b0;
			vb_q <= 1'b0;
			za_q <= 1'b1;
			zb_q <= 1'b1;
		end else begin
			if (req.we && req.waddr != '0) begin
				vld_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				va_q <= vld_q[req.ra];
				vb_q <= vld_q[req.rb];
				za_q <= (req.ra == '0);
				zb_q <= (req.rb == '0);
			end
		end
	end

	assign rd_a = za_q ? '0 : (va_q ? da_q : Poison);
	assign rd_b = zb_q ? '0 : (vb_q ? db_q : Poison);

endmodule

[src/mics_div.sv]
module mics_div import mics_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [31:0] d_q, q_q, r_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] r_sh, diff;

	// restoring divide, one quotient bit per cycle
	assign r_sh = {r_q, q_q[31]};
	assign diff = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			d_q <= req.divisor;
			q_q <= req.dividend;
			r_q <= '0;
		end else if (busy_q) begin
			if (!diff[32]) begin
				r_q <= diff[31:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= r_sh[31:0];
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = q_q;
	assign rsp.rem = r_q;

endmodule

[src/mics_checker.sv]
`include "assert_macros.svh"

module mics_checker import mics_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        inst_valid,
	input logic        inst_ready,
	input in_item_t    inst_item,
	input logic        res_valid,
	input logic        res_ready,
	input out_item_t   res_item,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [31:0] cfg_data
);

	`MICS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_item), "result dropped or changed while stalled")
	`MICS_ASSERT_NEXT(a_one_at_a_time, inst_valid && inst_ready, !inst_ready, "item accepted while another is at work")
	`MICS_ASSERT(a_fault_no_access, res_valid && res_item.status != StOk, res_item.mem_kind == KindNone && res_item.mem_address == '0, "faulting or halted result requests an access")
	`MICS_ASSERT(a_idle_fields, res_valid && res_item.mem_kind == KindNone, res_item.mem_size == SizeByte && res_item.store_data == '0, "unused access fields not cleared")

endmodule

bind mips_integer_core_step_top mics_checker u_chk (.*);

[bench/mics_core_checker.sv]
module mics_core_checker import mics_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        inst_valid,
	input  logic        inst_ready,
	input  in_item_t    inst_item,
	input  logic        res_valid,
	input  logic        res_ready,
	input  out_item_t   res_item,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          waiting
);

	logic [31:0] gpr [32];
	logic [31:0] pc, held, hi, lo, sr, boot_addr;
	logic [4:0]  pl_target;
	logic [1:0]  pl_mode;
	logic        pl_from_sr, halted;
	out_item_t   expected_q [$];

	task automatic put_gpr(input logic [4:0] idx, input logic [31:0] v);
		if (idx != 5'd0)
			gpr[idx] = v;
	endtask

	task automatic core_step(input in_item_t it, output out_item_t o);
		logic [31:0] ins, ld, rs, rt, imm, simm, addr, wv, an, ad, q, r, s;
		logic [5:0]  op, fn;
		logic [4:0]  rsi, rti, rdi, sa, wi, new_t;
		logic [1:0]  new_m;
		logic [2:0]  st;
		logic        wr, new_sr, iso;
		o = '0;
		if (halted) begin
			o.fetch_address = pc;
			o.status = StHalted;
			return;
		end
		iso = (sr & IsolateMask) != 0;
		ins = held;
		held = it.fetched_word;
		ld = it.load_data;
		pc = pc + DefWordBytes;
		op = ins[31:26];
		fn = ins[5:0];
		rsi = ins[25:21];
		rti = ins[20:16];
		rdi = ins[15:11];
		sa = ins[10:6];
		imm = {16'd0, ins[15:0]};
		simm = {{16{ins[15]}}, ins[15:0]};
		rs = gpr[rsi];
		rt = gpr[rti];
		addr = rs + simm;
		// the load issued last item lands before this instruction executes
		if (pl_from_sr)
			put_gpr(pl_target, sr);
		else case (pl_mode)
			PlWord:  put_gpr(pl_target, ld);
			PlSByte: put_gpr(pl_target, {{24{ld[7]}}, ld[7:0]});
			PlUByte: put_gpr(pl_target, ld & ByteMask);
			default: ;
		endcase
		pl_target = '0;
		pl_mode = PlNone;
		pl_from_sr = 1'b0;
		st = StOk;
		wr = 1'b0;
		wi = rdi;
		wv = '0;
		new_t = '0;
		new_m = PlNone;
		new_sr = 1'b0;
		case (op)
			OpSpecial: begin
				case (fn)
					FnSll: begin wr = 1; wv = rt << sa; end
					FnSrl: begin wr = 1; wv = rt >> sa; end
					FnSra: begin wr = 1; wv = $signed(rt) >>> sa; end
					FnJr: pc = rs;
					FnJalr: begin wr = 1; wv = pc; pc = rs; end
					FnMfhi: begin wr = 1; wv = hi; end
					FnMflo: begin wr = 1; wv = lo; end
					FnDiv: begin
						if (rt == 0) begin
							hi = rs;
							lo = rs[31] ? 32'd1 : AllOnes;
						end else if (rs == SignBit && rt == AllOnes) begin
							hi = 0;
							lo = SignBit;
						end else begin
							an = rs[31] ? -rs : rs;
							ad = rt[31] ? -rt : rt;
							q = an / ad;
							r = an % ad;
							if (rs[31] ^ rt[31]) q = -q;
							if (rs[31]) r = -r;
							hi = r;
							lo = q;
						end
					end
					FnDivu: begin
						if (rt == 0) begin
							hi = rs;
							lo = AllOnes;
						end else begin
							hi = rs % rt;
							lo = rs / rt;
						end
					end
					FnAdd: begin
						s = rs + rt;
						if (~(rs[31] ^ rt[31]) & (rs[31] ^ s[31])) st = StOverflow;
						else begin wr = 1; wv = s; end
					end
					FnAddu: begin wr = 1; wv = rs + rt; end
					FnSubu: begin wr = 1; wv = rs - rt; end
					FnAnd: begin wr = 1; wv = rs & rt; end
					FnOr: begin wr = 1; wv = rs | rt; end
					FnSlt: begin wr = 1; wv = ($signed(rs) < $signed(rt)) ? 1 : 0; end
					FnSltu: begin wr = 1; wv = (rs < rt) ? 1 : 0; end
					default: st = StBadOp;
				endcase
			end
			OpRegimm: begin
				// link happens whether or not the branch goes
				if (ins[20]) begin wr = 1; wi = LinkReg; wv = pc; end
				if (rs[31] ^ ins[16]) pc = pc + (simm << 2) - DefWordBytes;
			end
			OpJal: begin
				wr = 1; wi = LinkReg; wv = pc;
				pc = ((pc - DefWordBytes) & JumpRegionMask) | {4'd0, ins[25:0], 2'd0};
			end
			OpJ: pc = ((pc - DefWordBytes) & JumpRegionMask) | {4'd0, ins[25:0], 2'd0};
			OpBeq: if (rs == rt) pc = pc + (simm << 2) - DefWordBytes;
			OpBne: if (rs != rt) pc = pc + (simm << 2) - DefWordBytes;
			OpBlez: if (rs == 0 || rs[31]) pc = pc + (simm << 2) - DefWordBytes;
			OpBgtz: if (rs != 0 && !rs[31]) pc = pc + (simm << 2) - DefWordBytes;
			OpAddi: begin
				if (~(rs[31] ^ simm[31]) & (rs[31] ^ addr[31])) st = StOverflow;
				else begin wr = 1; wi = rti; wv = addr; end
			end
			OpAddiu: begin wr = 1; wi = rti; wv = addr; end
			OpSlti: begin wr = 1; wi = rti; wv = ($signed(rs) < $signed(simm)) ? 1 : 0; end
			OpSltiu: begin wr = 1; wi = rti; wv = (rs < simm) ? 1 : 0; end
			OpAndi: begin wr = 1; wi = rti; wv = rs & imm; end
			OpOri: begin wr = 1; wi = rti; wv = rs | imm; end
			OpLui: begin wr = 1; wi = rti; wv = imm << 16; end
			OpCop0: begin
				if (rsi == CopMt) begin
					if (rdi == Cp0Sr) sr = rt;
					else if (rdi inside {5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd11, 5'd13}) begin
						if (rt != 0) st = StBadCop;
					end else st = StBadCop;
				end else if (rsi == CopMf) begin
					if (rdi == Cp0Sr) begin new_sr = 1; new_t = rti; end
					else st = StBadCop;
				end else st = StBadCop;
			end
			OpLb: begin
				o.mem_kind = KindLoad; o.mem_size = SizeByte; o.mem_address = addr;
				new_t = rti; new_m = PlSByte;
			end
			OpLbu: begin
				o.mem_kind = KindLoad; o.mem_size = SizeByte; o.mem_address = addr;
				new_t = rti; new_m = PlUByte;
			end
			OpLw: if (!iso) begin
				o.mem_kind = KindLoad; o.mem_size = SizeWord; o.mem_address = addr;
				new_t = rti; new_m = PlWord;
			end
			OpSb: if (!iso) begin
				o.mem_kind = KindStore; o.mem_size = SizeByte; o.mem_address = addr;
				o.store_data = rt & ByteMask;
			end
			OpSh: if (!iso) begin
				o.mem_kind = KindStore; o.mem_size = SizeHalf; o.mem_address = addr;
				o.store_data = {16'd0, rt[15:0]};
			end
			OpSw: if (!iso) begin
				o.mem_kind = KindStore; o.mem_size = SizeWord; o.mem_address = addr;
				o.store_data = rt;
			end
			default: st = StBadOp;
		endcase
		if (st != StOk) begin
			halted = 1'b1;
			o.mem_kind = KindNone; o.mem_size = SizeByte;
			o.mem_address = '0; o.store_data = '0;
		end else begin
			// instruction write wins over the landing load
			if (wr) put_gpr(wi, wv);
			pl_target = new_t;
			pl_mode = new_m;
			pl_from_sr = new_sr;
		end
		o.fetch_address = pc;
		o.status = st;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t e, p;
		if (!arst_n) begin
			for (int i = 0; i < 32; i++)
				gpr[i] = Poison;
			gpr[0] = '0;
			boot_addr = ResetAddress;
			pc = ResetAddress;
			held = '0;
			hi = Poison;
			lo = Poison;
			sr = '0;
			pl_target = '0;
			pl_mode = PlNone;
			pl_from_sr = 1'b0;
			halted = 1'b0;
			expected_q.delete();
			errors = 0;
			waiting = 0;
		end else begin
			// the address is recorded only; reset always restarts at the default address
			if (cfg_valid && cfg_ready)
				boot_addr = cfg_data;
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected item %h", $time, res_item);
					errors++;
				end else begin
					e = expected_q.pop_front();
					check_field("fetch_address", e.fetch_address, res_item.fetch_address);
					check_field("mem_kind", e.mem_kind, res_item.mem_kind);
					check_field("mem_size", e.mem_size, res_item.mem_size);
					check_field("mem_address", e.mem_address, res_item.mem_address);
					check_field("store_data", e.store_data, res_item.store_data);
					check_field("status", e.status, res_item.status);
				end
			end
			if (inst_valid && inst_ready) begin
				core_step(inst_item, p);
				expected_q.push_back(p);
			end
			waiting = expected_q.size();
		end
	end

endmodule

[bench/tb_mips_integer_core_step_top.sv]
module tb_mips_integer_core_step_top;
	import mics_pkg::*;

	localparam int CycleLimit = 500000;
	localparam int RandomItems = 1050;
	localparam int QuietItems = 150;
	localparam logic [5:0] OpBad = 6'h3f;
	localparam logic [5:0] FnBad = 6'h01;
	localparam logic [4:0] Cp0Bad = 5'd1;
	localparam logic [4:0] Cp0Quiet [7] = '{5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd11, 5'd13};

	logic        clk = 0;
	logic        arst_n = 0;
	logic        inst_valid = 0;
	logic        inst_ready;
	in_item_t    inst_item = '0;
	logic        res_valid;
	logic        res_ready = 0;
	out_item_t   res_item;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	int          errors, waiting;
	int          cycles = 0;
	bit          quiet = 0;
	bit          long_hold = 0;

	always #2 clk = ~clk;

	mips_integer_core_step_top dut (
		.clk(clk), .arst_n(arst_n),
		.inst_valid(inst_valid), .inst_ready(inst_ready), .inst_item(inst_item),
		.res_valid(res_valid), .res_ready(res_ready), .res_item(res_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	mics_core_checker core_check (
		.clk(clk), .arst_n(arst_n),
		.inst_valid(inst_valid), .inst_ready(inst_ready), .inst_item(inst_item),
		.res_valid(res_valid), .res_ready(res_ready), .res_item(res_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .waiting(waiting)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [31:0] reg_op(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
			logic [4:0] rd, logic [4:0] sa);
		return {OpSpecial, rs, rt, rd, sa, fn};
	endfunction

	function automatic logic [31:0] imm_op(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] cop_op(logic [4:0] sub, logic [4:0] rt, logic [4:0] rd);
		return {OpCop0, sub, rt, rd, 11'd0};
	endfunction

	function automatic logic [15:0] pick_imm();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'h7fff;
			2: return 16'h8000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// fault-free instruction with random content
	function automatic logic [31:0] random_insn();
		logic [4:0]  a, b, c, sa;
		logic [15:0] imm;
		a = 5'($urandom);
		b = 5'($urandom);
		c = 5'($urandom);
		sa = 5'($urandom);
		imm = pick_imm();
		case ($urandom_range(0, 36))
			0: return reg_op(FnSll, a, b, c, sa);
			1: return reg_op(FnSrl, a, b, c, sa);
			2: return reg_op(FnSra, a, b, c, sa);
			3: return reg_op(FnJr, a, b, c, sa);
			4: return reg_op(FnJalr, a, b, c, sa);
			5: return reg_op(FnMfhi, a, b, c, sa);
			6: return reg_op(FnMflo, a, b, c, sa);
			7: return reg_op(FnDiv, a, b, c, sa);
			8: return reg_op(FnDivu, a, b, c, sa);
			9: return reg_op(FnAdd, a, 5'd0, c, sa);
			10: return reg_op(FnAddu, a, b, c, sa);
			11: return reg_op(FnSubu, a, b, c, sa);
			12: return reg_op(FnAnd, a, b, c, sa);
			13: return reg_op(FnOr, a, b, c, sa);
			14: return reg_op(FnSlt, a, b, c, sa);
			15: return reg_op(FnSltu, a, b, c, sa);
			16: return imm_op(OpRegimm, a, b, imm);
			17: return {OpJ, 26'($urandom)};
			18: return {OpJal, 26'($urandom)};
			19: return imm_op(OpBeq, a, b, imm);
			20: return imm_op(OpBne, a, b, imm);
			21: return imm_op(OpBlez, a, b, imm);
			22: return imm_op(OpBgtz, a, b, imm);
			23: return imm_op(OpAddi, 5'd0, b, imm);
			24: return imm_op(OpAddiu, a, b, imm);
			25: return imm_op($urandom_range(0, 1) ? OpSlti : OpSltiu, a, b, imm);
			26: return imm_op($urandom_range(0, 1) ? OpAndi : OpOri, a, b, imm);
			27, 28: return imm_op(OpLui, a, b, imm);
			29, 30, 31: begin
				case ($urandom_range(0, 2))
					0: return imm_op(OpLb, a, b, imm);
					1: return imm_op(OpLbu, a, b, imm);
					default: return imm_op(OpLw, a, b, imm);
				endcase
			end
			32, 33, 34: begin
				case ($urandom_range(0, 2))
					0: return imm_op(OpSb, a, b, imm);
					1: return imm_op(OpSh, a, b, imm);
					default: return imm_op(OpSw, a, b, imm);
				endcase
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return cop_op(CopMt, 5'd0, Cp0Sr);
					1: return cop_op(CopMt, b, Cp0Sr);
					2, 3: return cop_op(CopMf, b, Cp0Sr);
					default: return cop_op(CopMt, 5'd0, Cp0Quiet[$urandom_range(0, 6)]);
				endcase
			end
		endcase
	endfunction

	// called at a clock edge, returns at the edge where the item is taken, unless a random idle gap with valid low follows
	task automatic send(input logic [31:0] word);
		inst_valid <= 1'b1;
		inst_item <= '{fetched_word: word, load_data: $urandom};
		do @(posedge clk); while (!inst_ready);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			inst_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic settle_and_set(input logic [31:0] addr);
		inst_valid <= 1'b0;
		while (waiting != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= addr;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				res_ready <= 1'b0;
				repeat (250) @(posedge clk);
				long_hold = 0;
			end else if (arst_n && !quiet && $urandom_range(0, 6) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			res_ready <= arst_n;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		settle_and_set(32'h0000_0000);

		// build edge values, then walk through divides, shifts, compares, links, loads, stores and cop0 moves
		send(imm_op(OpLui, 5'd0, 5'd1, 16'h8000));
		send(imm_op(OpAddiu, 5'd0, 5'd2, 16'hffff));
		send(reg_op(FnDiv, 5'd1, 5'd2, 5'd0, 5'd0));
		send(reg_op(FnMflo, 5'd0, 5'd0, 5'd3, 5'd0));
		send(reg_op(FnMfhi, 5'd0, 5'd0, 5'd4, 5'd0));
		send(reg_op(FnDiv, 5'd1, 5'd0, 5'd0, 5'd0));
		send(reg_op(FnMflo, 5'd0, 5'd0, 5'd5, 5'd0));
		send(reg_op(FnDivu, 5'd2, 5'd0, 5'd0, 5'd0));
		send(reg_op(FnDiv, 5'd2, 5'd1, 5'd0, 5'd0));
		send(reg_op(FnSra, 5'd0, 5'd1, 5'd6, 5'd31));
		send(reg_op(FnSrl, 5'd0, 5'd2, 5'd7, 5'd31));
		send(reg_op(FnSll, 5'd0, 5'd2, 5'd8, 5'd31));
		send(reg_op(FnSlt, 5'd1, 5'd2, 5'd9, 5'd0));
		send(reg_op(FnSltu, 5'd1, 5'd2, 5'd9, 5'd0));
		send(reg_op(FnSubu, 5'd0, 5'd2, 5'd10, 5'd0));
		send(imm_op(OpAddi, 5'd0, 5'd11, 16'h8000));
		send(imm_op(OpRegimm, 5'd1, 5'd16, 16'h0004));
		send(imm_op(OpRegimm, 5'd2, 5'd17, 16'hfffc));
		send(imm_op(OpLw, 5'd1, 5'd12, 16'h8000));
		// load delay slot overwrites the load target
		send(imm_op(OpOri, 5'd0, 5'd12, 16'hffff));
		send(imm_op(OpLb, 5'd0, 5'd13, 16'h0001));
		send(imm_op(OpLbu, 5'd0, 5'd14, 16'h7fff));
		send(cop_op(CopMt, 5'd1, Cp0Sr));
		send(imm_op(OpLui, 5'd0, 5'd15, 16'h0001));
		send(cop_op(CopMt, 5'd15, Cp0Sr));
		send(imm_op(OpSw, 5'd2, 5'd2, 16'h0000));
		send(imm_op(OpLw, 5'd2, 5'd3, 16'h0000));
		send(imm_op(OpLb, 5'd2, 5'd3, 16'h0000));
		send(cop_op(CopMf, 5'd16, Cp0Sr));
		send(cop_op(CopMt, 5'd0, Cp0Sr));
		send(cop_op(CopMt, 5'd0, Cp0Quiet[0]));
		send(imm_op(OpSh, 5'd1, 5'd2, 16'h0002));
		send(imm_op(OpSb, 5'd1, 5'd2, 16'hffff));
		send(reg_op(FnJalr, 5'd2, 5'd0, 5'd31, 5'd0));
		send({OpJal, 26'h3ffffff});
		settle_and_set(32'hffff_ffff);

		for (int n = 0; n < RandomItems; n++) begin
			if (n == 300)
				long_hold = 1;
			if (n == 600)
				settle_and_set($urandom);
			if (n == RandomItems - QuietItems)
				quiet = 1;
			send(random_insn());
		end

		// one fault to finish, then the block reports halted
		case ($urandom_range(1, 3))
			1: send($urandom_range(0, 1) ? {OpBad, 26'($urandom)}
				: reg_op(FnBad, 5'($urandom), 5'($urandom), 5'($urandom), 5'd0));
			2: begin
				send(imm_op(OpLui, 5'd0, 5'd1, 16'h7fff));
				send(reg_op(FnAdd, 5'd1, 5'd1, 5'd2, 5'd0));
			end
			default: send(cop_op(CopMt, 5'($urandom), Cp0Bad));
		endcase
		repeat (6) send(random_insn());
		inst_valid <= 1'b0;
		while (waiting != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/mics_pkg.sv
src/mics_regfile.sv
src/mics_div.sv
src/mips_integer_core_step_top.sv
src/mics_checker.sv
bench/mics_core_checker.sv
bench/tb_mips_integer_core_step_top.sv
